[rtl/core/difference_of_gaussians_filter_macros.svh]
// ---------------------------------------------------------------------------
// difference of gaussians filter: assertion macros
// shared property forms for the checks at the end of the top level
// ---------------------------------------------------------------------------
`ifndef DIFFERENCE_OF_GAUSSIANS_FILTER_MACROS_SVH
`define DIFFERENCE_OF_GAUSSIANS_FILTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define DOG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define DOG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/dog_pkg.sv]
// ---------------------------------------------------------------------------
// dog_pkg
// beat types, codes and fixed constants of the difference of gaussians filter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dog_pkg;

	localparam int CFG_W = 12;

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_BIG_RADIUS   = 2'd2,
		REG_SMALL_RADIUS = 2'd3
	} cfg_reg_t;

	// input opcodes
	localparam logic [1:0] OP_PIXEL      = 2'd0;
	localparam logic [1:0] OP_LOAD_BIG   = 2'd1;
	localparam logic [1:0] OP_LOAD_SMALL = 2'd2;

	localparam logic [11:0] FRAME_WIDTH_RST  = 12'd1320;
	localparam logic [10:0] FRAME_HEIGHT_RST = 11'd760;
	localparam logic [4:0]  BIG_RADIUS_RST   = 5'd13;
	localparam logic [4:0]  SMALL_RADIUS_RST = 5'd10;

	// saturation bound of the result, 255.0 in q9.16
	localparam int DOG_LIMIT = 255 * 65536;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  pixel;
		logic [10:0] weight_index;
		logic [15:0] weight_value;
	} in_item_t;

	typedef struct packed {
		logic signed [24:0] dog_value;
		logic               end_of_frame;
	} out_item_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic write_pixel;
		logic write_big;
		logic write_small;
		logic clear;
		logic issue;
		logic sel_small;
		logic load_out;
		logic eof;
	} dog_cmd_t;

endpackage

`default_nettype wire

[rtl/core/dog_ctrl.sv]
// ---------------------------------------------------------------------------
// dog_ctrl
// configuration registers, raster position and window sequencer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dog_ctrl #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 1024,
	parameter int BORDER     = 20
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [1:0]                             cfg_index,
	input  logic [dog_pkg::CFG_W-1:0]              cfg_data,
	input  logic                                   pix_valid,
	output logic                                   pix_ready,
	input  logic [1:0]                             opcode,
	input  logic [10:0]                            weight_index,
	input  logic                                   out_full,
	output dog_pkg::dog_cmd_t                      cmd,
	output logic [$clog2(2*BORDER+1)-1:0]          wr_slot,
	output logic [$clog2(MAX_WIDTH)-1:0]           wr_col,
	output logic [$clog2(2*BORDER+1)-1:0]          rd_slot,
	output logic [$clog2(MAX_WIDTH)-1:0]           rd_col,
	output logic [$clog2((2*BORDER+1)*(2*BORDER+1))-1:0] rd_k
);
	import dog_pkg::*;

	localparam int STORE_ROWS   = 2 * BORDER + 1;
	localparam int KERNEL_CELLS = STORE_ROWS * STORE_ROWS;
	localparam int SW   = $clog2(STORE_ROWS);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RPW  = $clog2(MAX_HEIGHT);
	localparam int KW   = $clog2(KERNEL_CELLS);
	localparam int RADW = $clog2(BORDER + 1);
	localparam int WW   = CW + 1;
	localparam int HW   = RPW + 1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_BIG    = 5'b00010,
		ST_SMALL  = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t          state_q;
	logic [11:0]     fw_q;
	logic [10:0]     fh_q;
	logic [4:0]      rb_q;
	logic [4:0]      rs_q;
	logic [CW-1:0]   col_q;
	logic [RPW-1:0]  row_q;
	logic [SW-1:0]   slot_q;
	logic [SW-1:0]   ctr_slot_q;
	logic [CW-1:0]   ctr_col_q;
	logic            eof_q;
	logic [SW-1:0]   m_q;
	logic [SW-1:0]   n_q;
	logic [SW-1:0]   side_m1_q;
	logic [KW-1:0]   k_q;
	logic [SW-1:0]   rd_slot_q;
	logic [CW-1:0]   rd_col_q;
	logic            drain_q;

	logic [WW-1:0]   w_eff;
	logic [HW-1:0]   h_eff;
	logic [WW-1:0]   col_next;
	logic [HW-1:0]   row_next;
	logic            col_wrap;
	logic            row_wrap;
	logic            emit;
	logic            accept;
	logic            pix_acc;
	logic            idx_ok;
	logic [RADW-1:0] rb_eff;
	logic [RADW-1:0] rs_eff;
	logic [RADW-1:0] rad_cur;

	function automatic logic [RADW-1:0] clamp_rad(input logic [4:0] r);
		logic [5:0] re;
		re = {1'b0, r};
		if (re > 6'(BORDER)) begin
			return RADW'(BORDER);
		end
		return RADW'(r);
	endfunction

	// slot of the top window row: newest row slot minus border minus radius, mod store rows
	function automatic logic [SW-1:0] row_start(input logic [SW-1:0] slot,
		input logic [RADW-1:0] rad);
		logic [SW:0] s;
		s = {1'b0, slot} + (SW+1)'(STORE_ROWS - BORDER) - (SW+1)'(rad);
		if (s >= (SW+1)'(STORE_ROWS)) begin
			s = s - (SW+1)'(STORE_ROWS);
		end
		return s[SW-1:0];
	endfunction

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] slot);
		if (slot == SW'(STORE_ROWS - 1)) begin
			return '0;
		end
		return slot + SW'(1);
	endfunction

	always_comb begin
		priority if (fw_q == '0) begin
			w_eff = WW'(1);
		end else if ({1'b0, fw_q} > 13'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(fw_q);
		end
		priority if (fh_q == '0) begin
			h_eff = HW'(1);
		end else if ({1'b0, fh_q} > 12'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(fh_q);
		end
	end

	assign rb_eff   = clamp_rad(rb_q);
	assign rs_eff   = clamp_rad(rs_q);
	assign rad_cur  = (state_q == ST_BIG) ? rb_eff : rs_eff;
	assign col_next = WW'(col_q) + WW'(1);
	assign row_next = HW'(row_q) + HW'(1);
	assign col_wrap = col_next >= w_eff;
	assign row_wrap = row_next >= h_eff;
	assign emit     = (row_q >= RPW'(2 * BORDER)) && (col_q >= CW'(2 * BORDER)) &&
		(HW'(row_q) < h_eff) && (WW'(col_q) < w_eff);

	assign pix_ready = (state_q == ST_IDLE);
	assign accept    = pix_valid && pix_ready;
	assign pix_acc   = accept && (opcode == OP_PIXEL);
	assign idx_ok    = {21'd0, weight_index} < 32'(KERNEL_CELLS);

	always_comb begin
		cmd             = '0;
		cmd.write_pixel = pix_acc;
		cmd.write_big   = accept && (opcode == OP_LOAD_BIG) && idx_ok;
		cmd.write_small = accept && (opcode == OP_LOAD_SMALL) && idx_ok;
		cmd.clear       = pix_acc && emit;
		cmd.issue       = (state_q == ST_BIG) || (state_q == ST_SMALL);
		cmd.sel_small   = (state_q == ST_SMALL);
		cmd.load_out    = (state_q == ST_RESULT) && !out_full;
		cmd.eof         = eof_q;
	end

	assign wr_slot = slot_q;
	assign wr_col  = col_q;
	assign rd_slot = rd_slot_q;
	assign rd_col  = rd_col_q;
	assign rd_k    = k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q       <= FRAME_WIDTH_RST;
			fh_q       <= FRAME_HEIGHT_RST;
			rb_q       <= BIG_RADIUS_RST;
			rs_q       <= SMALL_RADIUS_RST;
			state_q    <= ST_IDLE;
			col_q      <= '0;
			row_q      <= '0;
			slot_q     <= '0;
			ctr_slot_q <= '0;
			ctr_col_q  <= '0;
			eof_q      <= 1'b0;
			m_q        <= '0;
			n_q        <= '0;
			side_m1_q  <= '0;
			k_q        <= '0;
			rd_slot_q  <= '0;
			rd_col_q   <= '0;
			drain_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_FRAME_WIDTH:  fw_q <= cfg_data[11:0];
					REG_FRAME_HEIGHT: fh_q <= cfg_data[10:0];
					REG_BIG_RADIUS:   rb_q <= cfg_data[4:0];
					REG_SMALL_RADIUS: rs_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pix_acc) begin
						if (col_wrap) begin
							col_q <= '0;
							if (row_wrap) begin
								row_q  <= '0;
								slot_q <= '0;
							end else begin
								row_q  <= row_q + RPW'(1);
								slot_q <= slot_inc(slot_q);
							end
						end else begin
							col_q <= col_q + CW'(1);
						end
						if (emit) begin
							ctr_slot_q <= slot_q;
							ctr_col_q  <= col_q;
							eof_q      <= col_wrap && row_wrap;
							rd_slot_q  <= row_start(slot_q, rb_eff);
							rd_col_q   <= col_q - CW'(BORDER) - CW'(rb_eff);
							m_q        <= '0;
							n_q        <= '0;
							k_q        <= '0;
							side_m1_q  <= SW'({rb_eff, 1'b0});
							state_q    <= ST_BIG;
						end
					end
				end
				ST_BIG, ST_SMALL: begin
					k_q <= k_q + KW'(1);
					if (n_q == side_m1_q) begin
						n_q       <= '0;
						rd_col_q  <= ctr_col_q - CW'(BORDER) - CW'(rad_cur);
						rd_slot_q <= slot_inc(rd_slot_q);
						if (m_q == side_m1_q) begin
							if (state_q == ST_BIG) begin
								rd_slot_q <= row_start(ctr_slot_q, rs_eff);
								rd_col_q  <= ctr_col_q - CW'(BORDER) - CW'(rs_eff);
								m_q       <= '0;
								k_q       <= '0;
								side_m1_q <= SW'({rs_eff, 1'b0});
								state_q   <= ST_SMALL;
							end else begin
								drain_q <= 1'b0;
								state_q <= ST_DRAIN;
							end
						end else begin
							m_q <= m_q + SW'(1);
						end
					end else begin
						n_q      <= n_q + SW'(1);
						rd_col_q <= rd_col_q + CW'(1);
					end
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (!out_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/dog_dp.sv]
// ---------------------------------------------------------------------------
// dog_dp
// line store, kernel memories, multiply-accumulate and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dog_dp #(
	parameter int MAX_WIDTH   = 2048,
	parameter int BORDER      = 20,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  dog_pkg::dog_cmd_t                      cmd,
	input  dog_pkg::in_item_t                      pix_data,
	input  logic [$clog2(2*BORDER+1)-1:0]          wr_slot,
	input  logic [$clog2(MAX_WIDTH)-1:0]           wr_col,
	input  logic [$clog2(2*BORDER+1)-1:0]          rd_slot,
	input  logic [$clog2(MAX_WIDTH)-1:0]           rd_col,
	input  logic [$clog2((2*BORDER+1)*(2*BORDER+1))-1:0] rd_k,
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output dog_pkg::out_item_t                     res_data,
	output logic                                   out_full
);
	import dog_pkg::*;

	localparam int STORE_ROWS   = 2 * BORDER + 1;
	localparam int KERNEL_CELLS = STORE_ROWS * STORE_ROWS;
	localparam int LS_DEPTH     = STORE_ROWS * MAX_WIDTH;
	localparam int LAW = $clog2(LS_DEPTH);
	localparam int KW  = $clog2(KERNEL_CELLS);
	localparam int PW  = 8 + WEIGHT_BITS;
	localparam int AW  = PW + KW;
	localparam int QW  = 24 + KW;
	localparam logic signed [QW:0] LIM_P = (QW+1)'(DOG_LIMIT);
	localparam logic signed [QW:0] LIM_N = -LIM_P;

	logic [7:0]             line_mem  [LS_DEPTH];
	logic [WEIGHT_BITS-1:0] big_mem   [KERNEL_CELLS];
	logic [WEIGHT_BITS-1:0] small_mem [KERNEL_CELLS];

	logic [LAW-1:0]            wr_addr;
	logic [LAW-1:0]            rd_addr;
	logic [KW-1:0]             wt_waddr;
	logic [WEIGHT_BITS+15:0]   wt_ext;
	logic [WEIGHT_BITS-1:0]    wt_wdata;
	logic [7:0]                pix_s1;
	logic [WEIGHT_BITS-1:0]    big_s1;
	logic [WEIGHT_BITS-1:0]    small_s1;
	logic                      v_s1;
	logic                      sel_s1;
	logic [PW-1:0]             prod_s2;
	logic                      v_s2;
	logic                      sel_s2;
	logic [AW-1:0]             big_acc_q;
	logic [AW-1:0]             small_acc_q;
	logic [QW-1:0]             big_q16;
	logic [QW-1:0]             small_q16;
	logic signed [QW:0]        diff;
	logic signed [24:0]        sat_val;
	logic                      res_valid_q;
	out_item_t                 res_data_q;

	assign wr_addr  = LAW'(wr_slot) * LAW'(MAX_WIDTH) + LAW'(wr_col);
	assign rd_addr  = LAW'(rd_slot) * LAW'(MAX_WIDTH) + LAW'(rd_col);
	assign wt_waddr = KW'(pix_data.weight_index);
	assign wt_ext   = {{WEIGHT_BITS{1'b0}}, pix_data.weight_value};
	assign wt_wdata = wt_ext[WEIGHT_BITS-1:0];

	always_ff @(posedge clk) begin
		if (cmd.write_pixel) begin
			line_mem[wr_addr] <= pix_data.pixel;
		end
		pix_s1 <= line_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.write_big) begin
			big_mem[wt_waddr] <= wt_wdata;
		end
		big_s1 <= big_mem[rd_k];
	end

	always_ff @(posedge clk) begin
		if (cmd.write_small) begin
			small_mem[wt_waddr] <= wt_wdata;
		end
		small_s1 <= small_mem[rd_k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			sel_s1      <= 1'b0;
			v_s2        <= 1'b0;
			sel_s2      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1   <= cmd.issue;
			sel_s1 <= cmd.sel_small;
			v_s2   <= v_s1;
			sel_s2 <= sel_s1;
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PW'(pix_s1) * PW'(sel_s1 ? small_s1 : big_s1);
		if (cmd.clear) begin
			big_acc_q   <= '0;
			small_acc_q <= '0;
		end else if (v_s2) begin
			if (sel_s2) begin
				small_acc_q <= small_acc_q + AW'(prod_s2);
			end else begin
				big_acc_q <= big_acc_q + AW'(prod_s2);
			end
		end
		if (cmd.load_out) begin
			res_data_q.dog_value    <= sat_val;
			res_data_q.end_of_frame <= cmd.eof;
		end
	end

	// bring both sums to 16 fraction bits
	generate
		if (WEIGHT_BITS >= 16) begin : g_shr
			assign big_q16   = QW'(big_acc_q >> (WEIGHT_BITS - 16));
			assign small_q16 = QW'(small_acc_q >> (WEIGHT_BITS - 16));
		end else begin : g_shl
			assign big_q16   = QW'(big_acc_q) << (16 - WEIGHT_BITS);
			assign small_q16 = QW'(small_acc_q) << (16 - WEIGHT_BITS);
		end
	endgenerate

	assign diff = $signed({1'b0, small_q16}) - $signed({1'b0, big_q16});

	always_comb begin
		priority if (diff > LIM_P) begin
			sat_val = LIM_P[24:0];
		end else if (diff < LIM_N) begin
			sat_val = LIM_N[24:0];
		end else begin
			sat_val = diff[24:0];
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;
	assign out_full  = res_valid_q && !res_ready;

endmodule

`default_nettype wire

[rtl/core/difference_of_gaussians_filter.sv]
// ---------------------------------------------------------------------------
// difference_of_gaussians_filter
// small-window minus large-window gaussian sum over a raster pixel stream
// ---------------------------------------------------------------------------
// usage
//   pix channel (valid/ready): one beat is a pixel or a kernel weight load,
//   selected by opcode. weight loads and pixels that have no interior center
//   never stall the input.
//   a pixel whose delayed center lies at least BORDER inside the frame starts
//   a window pass: one multiply-accumulate per cycle, large window first then
//   small, fed by one read port of the line store and of each kernel memory.
//   such a pixel holds off the next beat while both windows are walked
//   (clamped radii), the pipeline drains and the output register comes free.
//   res channel (valid/ready): one beat per interior center, end_of_frame set
//   on the last one of the frame. the result sits in an output register; if
//   the receiver stalls, a finished result waits there while the next pixel
//   is accepted, and a second result waits in the controller until it drains.
//   cfg port: plain write on cfg_we; user writes only while idle, unenforced.
//   reset clears position and restores register defaults; the line store and
//   kernel memories are not cleared and must be written before they are read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module difference_of_gaussians_filter #(
	parameter int MAX_WIDTH   = 2048,
	parameter int MAX_HEIGHT  = 1024,
	parameter int BORDER      = 20,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [dog_pkg::CFG_W-1:0] cfg_data,
	input  logic                      pix_valid,
	output logic                      pix_ready,
	input  dog_pkg::in_item_t         pix_data,
	output logic                      res_valid,
	input  logic                      res_ready,
	output dog_pkg::out_item_t        res_data
);
	import dog_pkg::*;

	localparam int STORE_ROWS   = 2 * BORDER + 1;
	localparam int KERNEL_CELLS = STORE_ROWS * STORE_ROWS;
	localparam int SW = $clog2(STORE_ROWS);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int KW = $clog2(KERNEL_CELLS);

	// controller to datapath commands and addresses
	dog_cmd_t      cmd;
	logic [SW-1:0] wr_slot;
	logic [CW-1:0] wr_col;
	logic [SW-1:0] rd_slot;
	logic [CW-1:0] rd_col;
	logic [KW-1:0] rd_k;
	// output register holds a beat the receiver has not taken
	logic          out_full;

	// sequencer: registers, raster position, window walk
	dog_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.BORDER    (BORDER)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.opcode      (pix_data.opcode),
		.weight_index(pix_data.weight_index),
		.out_full    (out_full),
		.cmd         (cmd),
		.wr_slot     (wr_slot),
		.wr_col      (wr_col),
		.rd_slot     (rd_slot),
		.rd_col      (rd_col),
		.rd_k        (rd_k)
	);

	// memories, mac pipeline, subtract and saturate, output register
	dog_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.BORDER     (BORDER),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.pix_data (pix_data),
		.wr_slot  (wr_slot),
		.wr_col   (wr_col),
		.rd_slot  (rd_slot),
		.rd_col   (rd_col),
		.rd_k     (rd_k),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data),
		.out_full (out_full)
	);

	// checks
`include "difference_of_gaussians_filter_macros.svh"

	// a result beat only appears after a window pass, never straight from idle
	`DOG_ASSERT_NOW(a_res_from_pass, $rose(res_valid), !$past(pix_ready), "result without window pass")
	// weight loads and unknown opcodes never stall the input
	`DOG_ASSERT_NEXT(a_load_no_stall, pix_valid && pix_ready && (pix_data.opcode != OP_PIXEL), pix_ready, "non-pixel beat stalled input")
	// the input only closes after a pixel beat
	`DOG_ASSERT_NOW(a_stall_after_pixel, $fell(pix_ready), $past(pix_valid) && ($past(pix_data.opcode) == OP_PIXEL), "input closed without pixel")

endmodule

`default_nettype wire

[sim/dog_checker.sv]
// ---------------------------------------------------------------------------
// dog_checker
// watches the pixel, result and register ports of the difference of
// gaussians filter, predicts each result and compares it field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dog_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [dog_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       pix_valid,
	input  logic                       pix_ready,
	input  dog_pkg::in_item_t          pix_data,
	input  logic                       res_valid,
	input  logic                       res_ready,
	input  dog_pkg::out_item_t         res_data,
	output int                         fail_count,
	output int                         pending
);
	import dog_pkg::*;

	localparam int EDGE_W    = 20;
	localparam int ROWS      = 2 * EDGE_W + 1;
	localparam int CELLS     = ROWS * ROWS;
	localparam int WIDTH_MAX = 2048;
	localparam int HEIGHT_MAX = 1024;

	logic [7:0]  pixel_rows [0:ROWS*WIDTH_MAX-1];
	logic [15:0] big_kernel [0:CELLS-1];
	logic [15:0] small_kernel [0:CELLS-1];
	int          row_at;
	int          col_at;
	logic [11:0] width_reg;
	logic [10:0] height_reg;
	logic [4:0]  big_rad_reg;
	logic [4:0]  small_rad_reg;
	out_item_t   dog_expected [$];

	function automatic longint window_total(input bit use_big, input int rad_in,
			input int cy, input int cx);
		int     rad;
		int     side;
		int     y;
		int     x;
		longint acc;
		rad = (rad_in > EDGE_W) ? EDGE_W : rad_in;
		side = 2 * rad + 1;
		acc = 0;
		for (int m = 0; m < side; m++) begin
			y = cy + m - rad;
			for (int n = 0; n < side; n++) begin
				x = cx + n - rad;
				acc += longint'(pixel_rows[(y % ROWS) * WIDTH_MAX + x]) *
					longint'(use_big ? big_kernel[m*side+n] : small_kernel[m*side+n]);
			end
		end
		return acc;
	endfunction

	task automatic take_pixel(input in_item_t item);
		int        w;
		int        h;
		bit        emit;
		bit        wrapped;
		int        cy;
		int        cx;
		longint    diff;
		out_item_t res;
		w = (width_reg > WIDTH_MAX) ? WIDTH_MAX : ((width_reg < 1) ? 1 : int'(width_reg));
		h = (height_reg > HEIGHT_MAX) ? HEIGHT_MAX : ((height_reg < 1) ? 1 : int'(height_reg));
		if (col_at < WIDTH_MAX)
			pixel_rows[(row_at % ROWS) * WIDTH_MAX + col_at] = item.pixel;
		emit = (row_at >= 2*EDGE_W) && (col_at >= 2*EDGE_W) && (row_at < h) && (col_at < w);
		cy = row_at - EDGE_W;
		cx = col_at - EDGE_W;
		wrapped = 1'b0;
		col_at++;
		if (col_at >= w) begin
			col_at = 0;
			row_at++;
			if (row_at >= h) begin
				row_at = 0;
				wrapped = 1'b1;
			end
		end
		if (emit) begin
			diff = window_total(1'b0, small_rad_reg, cy, cx) -
				window_total(1'b1, big_rad_reg, cy, cx);
			if (diff > DOG_LIMIT) diff = DOG_LIMIT;
			if (diff < -DOG_LIMIT) diff = -DOG_LIMIT;
			res.dog_value = diff[24:0];
			res.end_of_frame = wrapped;
			dog_expected.push_back(res);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			row_at = 0;
			col_at = 0;
			width_reg = FRAME_WIDTH_RST;
			height_reg = FRAME_HEIGHT_RST;
			big_rad_reg = BIG_RADIUS_RST;
			small_rad_reg = SMALL_RADIUS_RST;
			dog_expected.delete();
			fail_count = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (dog_expected.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result dog=%0d eof=%0b", $time,
						res_data.dog_value, res_data.end_of_frame);
				end else begin
					want = dog_expected.pop_front();
					if (res_data.dog_value !== want.dog_value) begin
						fail_count++;
						$display("%0t: dog_value expected %0d actual %0d", $time,
							want.dog_value, res_data.dog_value);
					end
					if (res_data.end_of_frame !== want.end_of_frame) begin
						fail_count++;
						$display("%0t: end_of_frame expected %0b actual %0b", $time,
							want.end_of_frame, res_data.end_of_frame);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_FRAME_WIDTH:  width_reg = cfg_data[11:0];
					REG_FRAME_HEIGHT: height_reg = cfg_data[10:0];
					REG_BIG_RADIUS:   big_rad_reg = cfg_data[4:0];
					REG_SMALL_RADIUS: small_rad_reg = cfg_data[4:0];
					default: ;
				endcase
			end
			if (pix_valid && pix_ready) begin
				case (pix_data.opcode)
					OP_PIXEL: take_pixel(pix_data);
					OP_LOAD_BIG:
						if (pix_data.weight_index < CELLS)
							big_kernel[pix_data.weight_index] = pix_data.weight_value;
					OP_LOAD_SMALL:
						if (pix_data.weight_index < CELLS)
							small_kernel[pix_data.weight_index] = pix_data.weight_value;
					default: ;
				endcase
			end
		end
		pending = dog_expected.size();
	end

endmodule

`default_nettype wire

[sim/tb_difference_of_gaussians_filter.sv]
// ---------------------------------------------------------------------------
// tb_difference_of_gaussians_filter
// streams two frames of pixels and kernel loads into the filter under random
// gaps and result back-pressure; the checker predicts and compares results
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_difference_of_gaussians_filter;
	import dog_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;   // undefined opcode, ignored
	localparam int KERNEL_CELLS = 1681;
	localparam int LOADED_CELLS = 81;        // cells of a radius-4 window
	localparam int MAX_RAD      = 4;
	localparam int CYCLE_LIMIT  = 1000000;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [1:0]      cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic            pix_valid;
	logic            pix_ready;
	in_item_t        pix_data;
	logic            res_valid;
	logic            res_ready;
	out_item_t       res_data;
	int              fail_count;
	int              pending;
	int              cycle_count;
	bit              no_gaps;       // stretches with no idling on the sender

	difference_of_gaussians_filter dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .pix_data(pix_data),
		.res_valid(res_valid), .res_ready(res_ready), .res_data(res_data)
	);

	dog_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .pix_data(pix_data),
		.res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// mostly moderate weights, some extremes that push into saturation
	function automatic int pick_weight();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return 0;
		if (roll == 1) return 65535;
		return $urandom_range(0, 2047);
	endfunction

	// receiver: bursts of ready, then stalls of random length
	initial begin
		int hold;
		hold = 0;
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if ($urandom_range(0, 9) < 7) begin
				res_ready = 1'b1;
				hold = $urandom_range(0, 30);
			end else begin
				res_ready = 1'b0;
				hold = pick_gap();
			end
		end
	end

	// one beat on the pixel channel, called and returning at a falling edge
	task automatic send_beat(input in_item_t item);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			pix_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_valid = 1'b1;
		pix_data = item;
		do @(posedge clk); while (!pix_ready);
		@(negedge clk);
	endtask

	task automatic send_load(input logic [1:0] op, input int idx, input int val);
		in_item_t item;
		item.opcode = op;
		item.pixel = 8'($urandom());
		item.weight_index = 11'(idx);
		item.weight_value = 16'(val);
		send_beat(item);
	endtask

	// wait until the block has nothing left to deliver
	task automatic drain();
		pix_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_W'(val);
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_data = CFG_W'($urandom());
	endtask

	task automatic set_frame(input int w, input int h);
		drain();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
	endtask

	task automatic set_radii(input int rb, input int rs);
		drain();
		write_reg(REG_BIG_RADIUS, rb);
		write_reg(REG_SMALL_RADIUS, rs);
	endtask

	// one whole frame of pixels with occasional weight reloads and noise;
	// radii change at the start of each row that yields results;
	// pause_left > 0 makes the sender wait for all results that many
	// pixels before the end
	task automatic run_frame(input int w, input int h, input int pause_left);
		int       wc;
		int       hc;
		int       total;
		int       style;
		int       idx;
		in_item_t item;
		wc = (w > 2048) ? 2048 : ((w < 1) ? 1 : w);
		hc = (h > 1024) ? 1024 : ((h < 1) ? 1 : h);
		total = wc * hc;
		style = $urandom_range(0, 3);
		no_gaps = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < total; i++) begin
			if ((i % wc == 0) && (i / wc >= 40)) begin
				set_radii($urandom_range(0, MAX_RAD), $urandom_range(0, MAX_RAD));
				style = $urandom_range(0, 3);
			end
			if (pause_left > 0 && i == total - pause_left) begin
				pix_valid = 1'b0;
				while (pending != 0) @(negedge clk);
			end
			if ($urandom_range(0, 99) < 5) begin
				idx = ($urandom_range(0, 9) == 0) ? $urandom_range(KERNEL_CELLS, 2047) :
					$urandom_range(0, LOADED_CELLS - 1);
				case ($urandom_range(0, 2))
					0: send_load(OP_NONE, $urandom(), $urandom());
					1: send_load(OP_LOAD_BIG, idx, pick_weight());
					default: send_load(OP_LOAD_SMALL, idx, pick_weight());
				endcase
			end
			item.opcode = OP_PIXEL;
			item.weight_index = 11'($urandom());
			item.weight_value = 16'($urandom());
			case (style)
				0: item.pixel = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				1: item.pixel = 8'd255;
				default: item.pixel = 8'($urandom());
			endcase
			send_beat(item);
		end
	endtask

	initial begin
		cycle_count = 0;
		no_gaps = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data = '0;
		pix_valid = 1'b0;
		pix_data = '0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: ignored opcode and out-of-range loads
		send_load(OP_NONE, 0, 16'hffff);
		send_load(OP_LOAD_BIG, KERNEL_CELLS, 16'hffff);
		send_load(OP_LOAD_SMALL, 2047, 16'hffff);

		// load every cell that a window of radius up to MAX_RAD reads
		for (int k = 0; k < LOADED_CELLS; k++) begin
			send_load(OP_LOAD_BIG, k, (k == 0) ? 0 : ((k == 1) ? 16'hffff : pick_weight()));
			send_load(OP_LOAD_SMALL, k, (k == 0) ? 16'hffff : ((k == 1) ? 0 : pick_weight()));
		end

		// sizes clamp to a single pixel; position stays at the origin
		set_frame(0, 0);
		run_frame(0, 0, 0);

		// one full frame, last pixel closes the frame with a result
		set_frame(48, 45);
		run_frame(48, 45, 3);

		pix_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl/core
rtl/core/dog_pkg.sv
rtl/core/dog_ctrl.sv
rtl/core/dog_dp.sv
rtl/core/difference_of_gaussians_filter.sv
sim/dog_checker.sv
sim/tb_difference_of_gaussians_filter.sv
